@@ rtl/core/b64e_pkg.sv @@
// Shared types, constants and the sextet-to-character mapping for the base64 encoder.
package b64e_pkg;

   // Default depth of the job queue between the front and back parts.
   localparam int B64E_QUEUE_DEPTH = 2;

   // Characters that are not taken from the alphabet.
   localparam logic [7:0] B64E_PAD_CHAR  = 8'h3D;
   localparam logic [7:0] B64E_TERM_CHAR = 8'h00;

   // Alphabet anchors.
   localparam logic [7:0] B64E_UPPER_BASE = 8'h41;
   localparam logic [7:0] B64E_LOWER_BASE = 8'h61 - 8'd26;
   localparam logic [7:0] B64E_DIGIT_BASE = 8'h30 - 8'd52;
   localparam logic [7:0] B64E_STD_62     = 8'h2B;
   localparam logic [7:0] B64E_STD_63     = 8'h2F;
   localparam logic [7:0] B64E_URL_62     = 8'h2D;
   localparam logic [7:0] B64E_URL_63     = 8'h5F;

   // One unit of output work: up to four sextets, padding and the terminator.
   typedef struct packed {
      logic [23:0] group;
      logic [2:0]  sext_cnt;
      logic [1:0]  pad_cnt;
      logic        term;
      logic        url_alpha;
   } b64e_job_type;

   // Map a 6-bit value onto the standard or URL-safe alphabet.
   function automatic logic [7:0] b64e_sextet_char(input logic [5:0] sextet,
                                                   input logic       url_alpha);
      logic [7:0] wide;
      logic [7:0] ch;
      wide = {2'b00, sextet};
      priority if (sextet < 6'd26) begin
         ch = B64E_UPPER_BASE + wide;
      end else if (sextet < 6'd52) begin
         ch = B64E_LOWER_BASE + wide;
      end else if (sextet < 6'd62) begin
         ch = B64E_DIGIT_BASE + wide;
      end else if (sextet == 6'd62) begin
         ch = url_alpha ? B64E_URL_62 : B64E_STD_62;
      end else begin
         ch = url_alpha ? B64E_URL_63 : B64E_STD_63;
      end
      return ch;
   endfunction

endpackage

@@ rtl/core/b64e_front.sv @@
// Front part: accepts message bytes, gathers groups of three and issues output jobs.
module b64e_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  url_alpha,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_in_byte,
   input  logic                  req_byte_present,
   input  logic                  req_end_of_message,
   input  logic                  q_full,
   output logic                  q_push,
   output b64e_pkg::b64e_job_type q_job
);
   import b64e_pkg::*;

   logic [15:0] pend_bytes_ff, pend_bytes_in;
   logic [1:0]  pend_count_ff, pend_count_in;
   logic        accept;
   logic        full_group;
   logic [15:0] mid_bytes;
   logic [1:0]  mid_count;
   b64e_job_type job;

   // A transaction is taken whenever the queue has room for its job.
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // Classify the item: add its byte, then flush on end of message.
   always_comb begin
      job        = '0;
      full_group = req_byte_present && (pend_count_ff >= 2'd2);
      mid_bytes  = pend_bytes_ff;
      mid_count  = pend_count_ff;
      job.url_alpha = url_alpha;

      if (req_byte_present) begin
         priority if (pend_count_ff >= 2'd2) begin
            job.group    = {pend_bytes_ff, req_in_byte};
            job.sext_cnt = 3'd4;
            mid_bytes    = '0;
            mid_count    = 2'd0;
         end else if (pend_count_ff == 2'd1) begin
            mid_bytes = {pend_bytes_ff[7:0], req_in_byte};
            mid_count = 2'd2;
         end else begin
            mid_bytes = {8'h00, req_in_byte};
            mid_count = 2'd1;
         end
      end

      if (req_end_of_message) begin
         job.term = 1'b1;
         if (mid_count == 2'd1) begin
            job.group    = {mid_bytes[7:0], 16'h0000};
            job.sext_cnt = 3'd2;
            job.pad_cnt  = url_alpha ? 2'd0 : 2'd2;
         end else if (mid_count == 2'd2) begin
            job.group    = {mid_bytes, 8'h00};
            job.sext_cnt = 3'd3;
            job.pad_cnt  = url_alpha ? 2'd0 : 2'd1;
         end
      end

      pend_bytes_in = pend_bytes_ff;
      pend_count_in = pend_count_ff;
      if (accept) begin
         pend_bytes_in = req_end_of_message ? 16'h0000 : mid_bytes;
         pend_count_in = req_end_of_message ? 2'd0 : mid_count;
      end
   end

   // Only items that produce characters become jobs.
   assign q_push = accept && (full_group || req_end_of_message);
   assign q_job  = job;

   // Pending-byte state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_count_ff <= 2'd0;
         pend_bytes_ff <= 16'h0000;
      end else begin
         pend_count_ff <= pend_count_in;
         pend_bytes_ff <= pend_bytes_in;
      end
   end

endmodule

@@ rtl/core/b64e_queue.sv @@
// Job queue that decouples the byte-accepting front from the character-emitting back.
module b64e_queue #(
   parameter int DEPTH = b64e_pkg::B64E_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  b64e_pkg::b64e_job_type push_job,
   output logic                  full,
   input  logic                  pop,
   output logic                  valid,
   output b64e_pkg::b64e_job_type pop_job
);
   import b64e_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   b64e_job_type     slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign valid   = (count_ff != '0);
   assign pop_job = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ rtl/core/b64e_back.sv @@
// Back part: expands each job into the output register, one character per cycle unless stalled.
module b64e_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  b64e_pkg::b64e_job_type q_job,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_char,
   output logic                  rsp_last_char
);
   import b64e_pkg::*;

   logic [23:0] group_ff, group_in;
   logic [2:0]  sext_left_ff, sext_left_in;
   logic [1:0]  pad_left_ff, pad_left_in;
   logic        term_ff, term_in;
   logic        url_ff, url_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_char_ff, out_char_in;
   logic        out_last_ff, out_last_in;
   logic        busy, emit, last_of_job;
   logic [2:0]  remaining;

   // Characters still owed by the current job.
   assign busy        = (sext_left_ff != 3'd0) || (pad_left_ff != 2'd0) || term_ff;
   assign remaining   = sext_left_ff + {1'b0, pad_left_ff} + {2'b00, term_ff};
   assign last_of_job = (remaining == 3'd1);
   assign emit        = busy && (!out_valid_ff || rsp_ready);
   assign q_pop       = q_valid && (!busy || (emit && last_of_job));

   // Pick the next character and advance the job; load the next job as this one ends or when idle.
   always_comb begin
      group_in     = group_ff;
      sext_left_in = sext_left_ff;
      pad_left_in  = pad_left_ff;
      term_in      = term_ff;
      url_in       = url_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_ready;

      if (emit) begin
         out_valid_in = 1'b1;
         priority if (sext_left_ff != 3'd0) begin
            out_char_in  = b64e_sextet_char(group_ff[23:18], url_ff);
            out_last_in  = 1'b0;
            group_in     = {group_ff[17:0], 6'b000000};
            sext_left_in = sext_left_ff - 3'd1;
         end else if (pad_left_ff != 2'd0) begin
            out_char_in = B64E_PAD_CHAR;
            out_last_in = 1'b0;
            pad_left_in = pad_left_ff - 2'd1;
         end else begin
            out_char_in = B64E_TERM_CHAR;
            out_last_in = 1'b1;
            term_in     = 1'b0;
         end
      end

      if (q_pop) begin
         group_in     = q_job.group;
         sext_left_in = q_job.sext_cnt;
         pad_left_in  = q_job.pad_cnt;
         term_in      = q_job.term;
         url_in       = q_job.url_alpha;
      end
   end

   // Job progress and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         sext_left_ff <= 3'd0;
         pad_left_ff  <= 2'd0;
         term_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         sext_left_ff <= sext_left_in;
         pad_left_ff  <= pad_left_in;
         term_ff      <= term_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      group_ff    <= group_in;
      url_ff      <= url_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_char  = out_char_ff;
   assign rsp_last_char = out_last_ff;

endmodule

@@ rtl/core/base64_stream_encoder_core.sv @@
// Streaming base64 encoder top level: mode register, front, job queue and back.
// With the back idle, a job for a group or for the end of the message passes a queue slot
// and the back's job registers before its first character leaves the output register.
// Throughput: a transaction every cycle while the job queue has room; the back sends one
// character a cycle unless the output stalls: four for three bytes, up to five for an end.
// Reset (synchronous, active high) clears the pending bytes, the queue, the back and the mode.
module base64_stream_encoder_core #(
   parameter int QUEUE_DEPTH = b64e_pkg::B64E_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_byte_present,
   input  logic       req_end_of_message,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_char
);
   import b64e_pkg::*;

   logic         url_alpha_ff;
   logic         q_push, q_full, q_pop, q_valid;
   b64e_job_type push_job, pop_job;

   // Mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         url_alpha_ff <= 1'b0;
      end else if (csr_write_enable) begin
         url_alpha_ff <= csr_write_data;
      end
   end

   b64e_front u_front (
      .clock              (clock),
      .reset              (reset),
      .url_alpha          (url_alpha_ff),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_job              (push_job)
   );

   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .pop_job  (pop_job)
   );

   b64e_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_job         (pop_job),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

   // The front never pushes a job into a full queue.
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("job pushed into a full queue");

   // The back only pops when a job is waiting.
   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("job popped from an empty queue");

   // The terminator transaction carries the zero character.
   a_term_is_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_char) |-> (rsp_out_char == B64E_TERM_CHAR))
      else $error("terminator carries a nonzero character");

   // Every other transaction carries an encoding character, which is never zero.
   a_char_nonzero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_char) |-> (rsp_out_char != B64E_TERM_CHAR))
      else $error("zero character without the last flag");

endmodule
